// ----- design/postfix_expression_evaluator_assert.svh -----
// Assertion macros used by the checker file.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define PEE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/pee_pkg.sv -----
// Package with token codes, status codes and payload widths of the evaluator.
`default_nettype none
package pee_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned InTdataW = 72;
  localparam int unsigned OutTdataW = 72;

  typedef logic [2:0] mode_t;
  localparam mode_t ModePush = 3'd0;
  localparam mode_t ModeAdd  = 3'd1;
  localparam mode_t ModeSub  = 3'd2;
  localparam mode_t ModeMul  = 3'd3;
  localparam mode_t ModeDiv  = 3'd4;
  localparam mode_t ModeEnd  = 3'd5;

  typedef logic [2:0] status_t;
  localparam status_t StOk        = 3'd0;
  localparam status_t StUnderflow = 3'd1;
  localparam status_t StCount     = 3'd2;
  localparam status_t StLookup    = 3'd3;
  localparam status_t StOverflow  = 3'd4;
  localparam status_t StDivZero   = 3'd5;

  // Request and reply between the sequencer and the arithmetic unit.
  typedef struct packed {
    logic  start;
    mode_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;
endpackage
`default_nettype wire

// ----- design/postfix_expression_evaluator.sv -----
// Top level of the postfix evaluator: token sequencer around a stack memory.
// One token is taken at a time. A push is written as it is taken; add and
// subtract go through two stack reads, the operand check, the start and the
// result of the arithmetic unit with the write-back; multiply retires two
// multiplier bits a cycle; divide one quotient bit a cycle plus the sign fix; a
// divide by zero ends at the operand check; an end token offers its result beat
// after a read of the stack bottom and holds the input until that beat is taken.
// The stack memory holds STACK_DEPTH words with a registered read, and the
// arithmetic unit is shared. The stack needs no clearing after reset.
`default_nettype none
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: [2:0] mode, [66:3] operand_value, [67] value_unresolved, rest zero
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: [2:0] status, [66:3] result_value, rest zero
  output logic [71:0]      out_tdata
);
  import pee_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_ALU, S_WAIT, S_ENDRD, S_OUT
  } state_t;

  state_t       state_r;
  logic [CW-1:0] count_r;
  status_t      err_r;
  mode_t        op_r;
  logic [63:0]  first_r;
  logic [63:0]  second_r;
  logic         start_r;
  logic [63:0]  mem [STACK_DEPTH];
  logic [63:0]  rd_data_r;
  logic         we;
  logic [AW-1:0] waddr;
  logic [63:0]  wdata;
  logic [AW-1:0] raddr;
  logic         out_valid_r;
  status_t      out_status_r;
  logic [63:0]  out_value_r;
  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [63:0]  alu_res;
  mode_t        in_mode;
  logic [63:0]  in_value;
  logic         in_unres;
  logic         in_fire;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;

  assign in_mode  = in_tdata[2:0];
  assign in_value = in_tdata[66:3];
  assign in_unres = in_tdata[67];
  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cnt_m1   = count_r - CW'(1);
  assign cnt_m2   = count_r - CW'(2);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_value_r, out_status_r};

  // Stack memory with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // Memory address and write selection.
  always_comb begin
    we    = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = in_value;
    raddr = cnt_m1[AW-1:0];
    priority case (state_r)
      S_IDLE: begin
        we = in_fire && (in_mode == ModePush) && (err_r == StOk) && !in_unres &&
             (count_r < CW'(STACK_DEPTH));
        raddr = '0;
      end
      S_RD1:  raddr = cnt_m1[AW-1:0];
      S_RD2:  raddr = cnt_m2[AW-1:0];
      S_WAIT: begin
        we    = alu_rsp.done;
        waddr = cnt_m2[AW-1:0];
        wdata = alu_res;
      end
      default: raddr = '0;
    endcase
  end

  assign alu_req.start = start_r;
  assign alu_req.op    = op_r;

  pee_alu u_alu (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (alu_req),
    .first_op  (first_r),
    .second_op (second_r),
    .rsp       (alu_rsp),
    .result    (alu_res)
  );

  // Token sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= StOk;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      // Start the arithmetic unit once both operands sit in their registers.
      start_r <= (state_r == S_ALU) && !(op_r == ModeDiv && rd_data_r == 64'd0);
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r <= in_mode;
            if (in_mode == ModeEnd) begin
              state_r <= S_ENDRD;
            end else if (in_mode <= ModeDiv && err_r == StOk) begin
              if (in_mode == ModePush) begin
                if (in_unres) begin
                  err_r <= StLookup;
                end else if (count_r >= CW'(STACK_DEPTH)) begin
                  err_r <= StOverflow;
                end else begin
                  count_r <= count_r + CW'(1);
                end
              end else if (count_r < CW'(2)) begin
                err_r <= StUnderflow;
              end else begin
                state_r <= S_RD1;
              end
            end
          end
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: begin
          first_r <= rd_data_r;
          state_r <= S_ALU;
        end
        S_ALU: begin
          second_r <= rd_data_r;
          if (op_r == ModeDiv && rd_data_r == 64'd0) begin
            err_r   <= StDivZero;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            count_r <= cnt_m1;
            state_r <= S_IDLE;
          end
        end
        S_ENDRD: begin
          state_r <= S_OUT;
        end
        default: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            if (err_r != StOk) begin
              out_status_r <= err_r;
              out_value_r  <= '0;
            end else if (count_r == CW'(1)) begin
              out_status_r <= StOk;
              out_value_r  <= rd_data_r;
            end else begin
              out_status_r <= StCount;
              out_value_r  <= '0;
            end
          end else if (out_tready) begin
            out_valid_r <= 1'b0;
            count_r     <= '0;
            err_r       <= StOk;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/pee_alu.sv -----
// Multi-cycle arithmetic unit: add, subtract, shift-add multiply, restoring divide.
`default_nettype none
module pee_alu (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pee_pkg::alu_req_t        req,
  input  wire logic [63:0]              first_op,
  input  wire logic [63:0]              second_op,
  output pee_pkg::alu_rsp_t             rsp,
  output logic [63:0]                   result
);
  import pee_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIX} astate_t;

  astate_t     state_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [64:0] rem_r;
  logic        neg_r;
  logic        done_r;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;

  // One restoring-division step: shift in the next dividend bit and try to subtract.
  assign rem_sh  = {rem_r[63:0], a_r[63]};
  assign rem_sub = rem_sh - {1'b0, b_r};

  assign rsp.done = done_r;
  assign result   = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      // Done pulses after an add or subtract, the last multiply step or the sign fix.
      done_r <= ((state_r == A_IDLE) && req.start &&
                 ((req.op == ModeAdd) || (req.op == ModeSub))) ||
                ((state_r == A_MUL) && (cnt_r == 6'd31)) ||
                (state_r == A_FIX);
      unique case (state_r)
        A_IDLE: begin
          if (req.start) begin
            cnt_r <= 6'd0;
            priority case (req.op)
              ModeAdd: begin
                acc_r <= first_op + second_op;
              end
              ModeSub: begin
                acc_r <= first_op - second_op;
              end
              ModeMul: begin
                acc_r   <= '0;
                a_r     <= first_op;
                b_r     <= second_op;
                state_r <= A_MUL;
              end
              default: begin
                a_r     <= first_op[63] ? (~first_op + 64'd1) : first_op;
                b_r     <= second_op[63] ? (~second_op + 64'd1) : second_op;
                neg_r   <= first_op[63] ^ second_op[63];
                rem_r   <= '0;
                acc_r   <= '0;
                state_r <= A_DIV;
              end
            endcase
          end
        end
        // Two multiplier bits per cycle.
        A_MUL: begin
          acc_r <= acc_r + (b_r[0] ? a_r : 64'd0) + (b_r[1] ? {a_r[62:0], 1'b0} : 64'd0);
          a_r   <= {a_r[61:0], 2'b00};
          b_r   <= {2'b00, b_r[63:2]};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            state_r <= A_IDLE;
          end
        end
        A_DIV: begin
          a_r <= {a_r[62:0], 1'b0};
          if (!rem_sub[64]) begin
            rem_r <= rem_sub;
            acc_r <= {acc_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            acc_r <= {acc_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            state_r <= A_FIX;
          end
        end
        default: begin
          if (neg_r) begin
            acc_r <= ~acc_r + 64'd1;
          end
          state_r <= A_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/pee_checker.sv -----
// Port-level checker for the evaluator, bound to the top level.
`default_nettype none
`include "postfix_expression_evaluator_assert.svh"
module pee_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [71:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);
  // A stalled result beat holds.
  `PEE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  // A non-ok status carries a zero value.
  `PEE_ASSERT_SAME(a_err_zero, clk, rst_n, out_tvalid && out_tdata[2:0] != 3'd0, out_tdata[66:3] == 64'd0, "error result carries a value")
  // Status is a defined code and the spare bits are zero.
  `PEE_ASSERT_SAME(a_status_code, clk, rst_n, out_tvalid, out_tdata[2:0] <= 3'd5 && out_tdata[71:67] == 5'd0, "bad status code")
  // The block takes no token while a result is pending.
  `PEE_ASSERT_SAME(a_no_in_pending, clk, rst_n, out_tvalid, !in_tready, "token taken while result pending")
endmodule

bind postfix_expression_evaluator pee_checker u_pee_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire

// ----- verif/postfix_expression_evaluator_tb.sv -----
// Self-checking testbench for the postfix expression evaluator stream block.
`default_nettype none
module postfix_expression_evaluator_tb;
  import pee_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;
  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic        unresolved;
    logic [63:0] value;
    mode_t       mode;
  } token_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] value;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  postfix_expression_evaluator #(.STACK_DEPTH(Depth)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  // Predictor state: the operand stack, its fill and the first error seen.
  logic [63:0] calc_stack [Depth];
  int unsigned calc_count = 0;
  status_t     calc_error = StOk;

  token_t   pending_tokens[$];
  verdict_t expected_verdicts[$];
  int unsigned failures = 0;
  bit       calm_source = 1'b0;
  bit       calm_sink = 1'b0;
  int unsigned hold_sink = 0;

  // Signed division truncating toward zero; minimum over minus one wraps.
  function automatic logic [63:0] quot_trunc(logic [63:0] a, logic [63:0] b);
    logic [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // Advance the predicted evaluator by one accepted token.
  function automatic void evaluate_token(token_t t);
    logic [63:0] first, second, r;
    verdict_t v;
    if (t.mode == ModeEnd) begin
      v.status = calc_error;
      v.value = '0;
      if (calc_error == StOk) begin
        if (calc_count == 1) v.value = calc_stack[0];
        else v.status = StCount;
      end
      expected_verdicts.push_back(v);
      calc_count = 0;
      calc_error = StOk;
      return;
    end
    if (t.mode > ModeEnd || calc_error != StOk) return;
    if (t.mode == ModePush) begin
      if (t.unresolved) calc_error = StLookup;
      else if (calc_count >= Depth) calc_error = StOverflow;
      else begin
        calc_stack[calc_count] = t.value;
        calc_count++;
      end
      return;
    end
    if (calc_count < 2) begin
      calc_error = StUnderflow;
      return;
    end
    first = calc_stack[calc_count-1];
    second = calc_stack[calc_count-2];
    case (t.mode)
      ModeAdd: r = first + second;
      ModeSub: r = first - second;
      ModeMul: r = first * second;
      default: begin
        if (second == '0) begin
          calc_error = StDivZero;
          return;
        end
        r = quot_trunc(first, second);
      end
    endcase
    calc_count--;
    calc_stack[calc_count-1] = r;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return MinVal;
      1: return MaxVal;
      2: return 64'hffff_ffff_ffff_ffff;
      3: return 64'($urandom_range(0, 20)) - 64'd10;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void queue_token(mode_t m, logic [63:0] v, logic u);
    token_t t;
    t.mode = m;
    t.value = v;
    t.unresolved = u;
    pending_tokens.push_back(t);
  endfunction

  // Well-formed expression with random content: a push, then push and operator pairs.
  function automatic void queue_expression();
    int unsigned n, depth_now;
    n = $urandom_range(1, 6);
    queue_token(ModePush, rand_word(), 1'b0);
    for (int i = 1; i < n; i++) begin
      queue_token(ModePush, rand_word(), 1'b0);
      // Mul and div are slow; keep them less frequent.
      queue_token(mode_t'($urandom_range(0, 9) < 6 ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 4)),
                  rand_word(), 1'b0);
    end
    queue_token(ModeEnd, rand_word(), $urandom_range(0, 1));
  endfunction

  // Driver: present the next queued token, idling at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_tokens.size() > 0 && (calm_source || $urandom_range(0, 99) >= 37)) begin
          in_tdata <= {4'b0, pending_tokens[0]};
          in_tvalid <= 1'b1;
          void'(pending_tokens.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Predict on each accepted input beat.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) evaluate_token(token_t'(in_tdata[67:0]));
  end

  // Sink ready: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_sink > 0) begin
      hold_sink <= hold_sink - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm_sink || ($urandom_range(0, 99) >= 37);
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        failures++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_tdata[2:0] != want.status) begin
          $error("status expected %0d actual %0d", want.status, out_tdata[2:0]);
          failures++;
        end
        if (out_tdata[66:3] != want.value) begin
          $error("result_value expected %h actual %h", want.value, out_tdata[66:3]);
          failures++;
        end
      end
    end
  end

  initial begin
    // Directed: operations, extremes and every error path.
    queue_token(ModePush, MaxVal, 1'b0); queue_token(ModePush, 64'd1, 1'b0);
    queue_token(ModeAdd, '0, 1'b0); queue_token(ModeEnd, '0, 1'b0);
    queue_token(ModePush, 64'd3, 1'b0); queue_token(ModePush, MinVal, 1'b0);
    queue_token(ModeSub, '0, 1'b0); queue_token(ModeEnd, '0, 1'b0);
    queue_token(ModePush, 64'hffff_ffff_ffff_ffff, 1'b0);
    queue_token(ModePush, MinVal, 1'b0); queue_token(ModeDiv, '0, 1'b0);
    queue_token(ModePush, -64'd7, 1'b0); queue_token(ModeMul, '0, 1'b0);
    queue_token(ModeEnd, '0, 1'b0);
    queue_token(ModePush, '0, 1'b0); queue_token(ModePush, 64'd5, 1'b0);
    queue_token(ModeDiv, '0, 1'b0); queue_token(ModeEnd, '0, 1'b0);
    queue_token(ModeAdd, '0, 1'b0); queue_token(ModeEnd, '0, 1'b0);
    queue_token(ModePush, 64'd1, 1'b1); queue_token(ModeEnd, '0, 1'b0);
    queue_token(ModeEnd, '0, 1'b0);
    queue_token(mode_t'(3'd6), '0, 1'b0); queue_token(mode_t'(3'd7), MaxVal, 1'b1);
    for (int i = 0; i <= Depth; i++) queue_token(ModePush, 64'(i), 1'b0);
    queue_token(ModeEnd, '0, 1'b0);
    queue_token(ModePush, 64'd2, 1'b0); queue_token(ModePush, 64'd9, 1'b0);
    queue_token(ModeEnd, '0, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Long hold-off on the sink while the source keeps offering.
    calm_source = 1'b1;
    hold_sink = 300;
    wait (pending_tokens.size() == 0);
    calm_source = 1'b0;

    // Random: mostly well-formed expressions, some noise.
    while (pending_tokens.size() < 700) begin
      if ($urandom_range(0, 9) < 8) queue_expression();
      else queue_token(mode_t'($urandom_range(0, 7)), rand_word(), $urandom_range(0, 3) == 0);
      if (pending_tokens.size() > 300 && pending_tokens.size() < 310) begin
        calm_source = 1'b1;
        calm_sink = 1'b1;
      end
    end
    queue_token(ModeEnd, '0, 1'b0);
    wait (pending_tokens.size() < 150);
    calm_source = 1'b0;
    calm_sink = 1'b0;
    wait (pending_tokens.size() == 0);
    @(posedge clk);
    while (in_tvalid) @(posedge clk);
    wait (expected_verdicts.size() == 0);
    repeat (200) @(posedge clk);
    if (failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
